FILE: hw/rtl/spq_pkg.sv
package spq_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int ID_BITS_DEF   = 16;
  localparam int PRIO_BITS_DEF = 8;

  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 3;

  localparam logic [OP_BITS-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_UPDATE = 2'd2;
  localparam logic [OP_BITS-1:0] OP_SERVE  = 2'd3;

  localparam logic [STATUS_BITS-1:0] STAT_ADDED     = 3'd0;
  localparam logic [STATUS_BITS-1:0] STAT_REMOVED   = 3'd1;
  localparam logic [STATUS_BITS-1:0] STAT_UPDATED   = 3'd2;
  localparam logic [STATUS_BITS-1:0] STAT_SERVED    = 3'd3;
  localparam logic [STATUS_BITS-1:0] STAT_EMPTY     = 3'd4;
  localparam logic [STATUS_BITS-1:0] STAT_NOT_FOUND = 3'd5;
  localparam logic [STATUS_BITS-1:0] STAT_FULL      = 3'd6;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL
  } cell_cmd_t;

  // handed from each cell to the next one towards the tail
  typedef struct packed {
    logic ge;    // this slot is occupied and has priority >= key
    logic seen;  // deletion point lies at or before this slot
  } link_t;

endpackage

FILE: hw/rtl/stable_priority_queue_with_update_core.sv
// A request is registered in the idle state and its result is loaded in the execute
// state; update runs a delete pass there and then an insert pass in the insert state.
// No new request is taken until the last result has been loaded (req_stall).
// A request is taken while an earlier result still waits at the output.
// Reset clears the entry count, control state and output valid; slot contents
// are left as they are and never read before being written.
module stable_priority_queue_with_update_core
  import spq_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  localparam int CNT_BITS = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic [OP_BITS-1:0]     operation,
  input  logic [ID_BITS-1:0]     entry_id,
  input  logic [PRIO_BITS-1:0]   priority_req,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic [STATUS_BITS-1:0] status,
  output logic [ID_BITS-1:0]     served_id,
  output logic [CNT_BITS-1:0]    occupancy
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_INS  = 2'd2;

  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(CAPACITY);

  logic [1:0]           state, state_next;
  logic [CNT_BITS-1:0]  count, count_next;
  logic [OP_BITS-1:0]   op;
  logic [ID_BITS-1:0]   key_id;
  logic [PRIO_BITS-1:0] key_prio;

  cell_cmd_t            cmd;
  logic                 seed;
  logic                 found;
  logic                 ofree;
  logic                 rsp_load;
  logic [STATUS_BITS-1:0] status_next;
  logic [ID_BITS-1:0]   sid_next;

  logic [ID_BITS-1:0]   cell_id   [CAPACITY];
  logic [PRIO_BITS-1:0] cell_prio [CAPACITY];
  link_t                link      [CAPACITY+1];

  assign req_stall = (state != ST_IDLE);
  assign ofree     = !rsp_valid || !rsp_stall;

  assign link[0].ge   = 1'b1;
  assign link[0].seen = seed;
  assign found        = link[CAPACITY].seen;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ID_BITS-1:0]   l_id, r_id;
    logic [PRIO_BITS-1:0] l_prio, r_prio;
    logic                 occ;

    assign occ = (CNT_BITS'(i) < count);

    if (i == 0) begin : g_head
      assign l_id   = key_id;
      assign l_prio = key_prio;
    end else begin : g_mid
      assign l_id   = cell_id[i-1];
      assign l_prio = cell_prio[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_id   = cell_id[i];
      assign r_prio = cell_prio[i];
    end else begin : g_body
      assign r_id   = cell_id[i+1];
      assign r_prio = cell_prio[i+1];
    end

    spq_cell #(
      .ID_BITS   (ID_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occ        (occ),
      .key_id     (key_id),
      .key_prio   (key_prio),
      .link_in    (link[i]),
      .link_out   (link[i+1]),
      .left_id    (l_id),
      .left_prio  (l_prio),
      .right_id   (r_id),
      .right_prio (r_prio),
      .id         (cell_id[i]),
      .prio       (cell_prio[i])
    );
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    cmd         = CMD_HOLD;
    seed        = (op == OP_SERVE);
    rsp_load    = 1'b0;
    status_next = STAT_ADDED;
    sid_next    = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (ofree) begin
          state_next = ST_IDLE;
          rsp_load   = 1'b1;
          if (op == OP_ADD) begin
            if (count == FULL_COUNT) begin
              status_next = STAT_FULL;
            end else begin
              cmd         = CMD_INS;
              count_next  = count + 1'b1;
              status_next = STAT_ADDED;
            end
          end else if (count == '0) begin
            status_next = STAT_EMPTY;
          end else if (op == OP_SERVE) begin
            cmd         = CMD_DEL;
            count_next  = count - 1'b1;
            status_next = STAT_SERVED;
            sid_next    = cell_id[0];
          end else if (!found) begin
            status_next = STAT_NOT_FOUND;
          end else if (op == OP_REMOVE) begin
            cmd         = CMD_DEL;
            count_next  = count - 1'b1;
            status_next = STAT_REMOVED;
            sid_next    = key_id;
          end else begin
            cmd        = CMD_DEL;
            count_next = count - 1'b1;
            rsp_load   = 1'b0;
            state_next = ST_INS;
          end
        end
      end
      ST_INS: begin
        if (ofree) begin
          cmd         = CMD_INS;
          count_next  = count + 1'b1;
          status_next = STAT_UPDATED;
          rsp_load    = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      op       <= operation;
      key_id   <= entry_id;
      key_prio <= priority_req;
    end
    if (rsp_load) begin
      status    <= status_next;
      served_id <= sid_next;
      occupancy <= count_next;
    end
  end

endmodule

FILE: hw/rtl/spq_cell.sv
module spq_cell
  import spq_pkg::*;
#(
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF
) (
  input  logic                 clk,
  input  cell_cmd_t            cmd,
  input  logic                 occ,
  input  logic [ID_BITS-1:0]   key_id,
  input  logic [PRIO_BITS-1:0] key_prio,
  input  link_t                link_in,
  output link_t                link_out,
  input  logic [ID_BITS-1:0]   left_id,
  input  logic [PRIO_BITS-1:0] left_prio,
  input  logic [ID_BITS-1:0]   right_id,
  input  logic [PRIO_BITS-1:0] right_prio,
  output logic [ID_BITS-1:0]   id,
  output logic [PRIO_BITS-1:0] prio
);

  logic ge;
  logic hit;
  logic del_here;

  assign ge       = occ && (prio >= key_prio);
  assign hit      = occ && (id == key_id);
  assign del_here = link_in.seen || hit;

  assign link_out.ge   = ge;
  assign link_out.seen = del_here;

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_INS: begin
        if (!ge) begin
          if (link_in.ge) begin
            id   <= key_id;
            prio <= key_prio;
          end else begin
            id   <= left_id;
            prio <= left_prio;
          end
        end
      end
      CMD_DEL: begin
        if (del_here) begin
          id   <= right_id;
          prio <= right_prio;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/spq_check.sv
module spq_check
  import spq_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int PRIO_BITS = PRIO_BITS_DEF,
  localparam int CNT_BITS = $clog2(CAPACITY + 1)
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_stall,
  input logic [OP_BITS-1:0]     operation,
  input logic [ID_BITS-1:0]     entry_id,
  input logic [PRIO_BITS-1:0]   priority_req,
  input logic                   rsp_valid,
  input logic                   rsp_stall,
  input logic [STATUS_BITS-1:0] status,
  input logic [ID_BITS-1:0]     served_id,
  input logic [CNT_BITS-1:0]    occupancy
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(served_id)
      && $stable(occupancy))
    else $error("stalled result changed");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == STAT_FULL) |-> occupancy == CNT_BITS'(CAPACITY))
    else $error("full reported below capacity");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == STAT_EMPTY) |-> occupancy == '0)
    else $error("empty reported with entries held");

  a_sid_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != STAT_SERVED) && (status != STAT_REMOVED)
      |-> served_id == '0)
    else $error("served id set on a non-removing result");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while one is in progress");

endmodule

bind stable_priority_queue_with_update_core spq_check #(
  .CAPACITY  (CAPACITY),
  .ID_BITS   (ID_BITS),
  .PRIO_BITS (PRIO_BITS)
) u_spq_check (.*);
